// ===== design/node_table_upsert_defines.svh =====
// Assertion helpers for the node table.
`ifndef NODE_TABLE_UPSERT_DEFINES_SVH
`define NODE_TABLE_UPSERT_DEFINES_SVH

// Same-cycle implication.
`define NTU_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NTU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ntu_pkg.sv =====
package ntu_pkg;

  localparam int DEF_TABLE_ENTRIES = 16;
  localparam int ID_W              = 8;
  localparam int LEN_W             = 8;
  localparam int SLOT_W            = 4;
  localparam int ENV_W             = 64;
  localparam int PART_W            = 24;
  localparam logic [LEN_W-1:0] CFG_LEN_RESET = 8'd11;

  typedef enum logic [1:0] {
    OUT_UPDATED = 2'd0,
    OUT_NEW     = 2'd1,
    OUT_FULL    = 2'd2
  } outcome_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } state_t;

  typedef struct packed {
    logic match;
    logic free;
  } lookup_t;

  typedef struct packed {
    logic [31:0]       count;
    logic [31:0]       last_seen;
    logic [7:0]        hops;
    logic signed [7:0] rssi;
  } stat_t;

  typedef struct packed {
    logic [PART_W-1:0] particle;
    logic [ENV_W-1:0]  env;
  } reading_t;

endpackage

// ===== design/ntu_lookup.sv =====
module ntu_lookup #(
  parameter int TABLE_ENTRIES = ntu_pkg::DEF_TABLE_ENTRIES,
  parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
  input  logic [TABLE_ENTRIES-1:0]                   active,
  input  logic [TABLE_ENTRIES-1:0][ntu_pkg::ID_W-1:0] ids,
  input  logic [ntu_pkg::ID_W-1:0]                   key,
  output ntu_pkg::lookup_t                           flags,
  output logic [IDX_W-1:0]                           idx
);
  import ntu_pkg::*;

  logic             match_found;
  logic             free_found;
  logic [IDX_W-1:0] match_idx;
  logic [IDX_W-1:0] free_idx;

  // Scan high to low so the lowest index wins.
  always_comb begin
    match_found = 1'b0;
    free_found  = 1'b0;
    match_idx   = '0;
    free_idx    = '0;
    for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
      if (active[k] && (ids[k] == key)) begin
        match_found = 1'b1;
        match_idx   = IDX_W'(k);
      end
      if (!active[k]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(k);
      end
    end
  end

  assign flags.match = match_found;
  assign flags.free  = free_found;
  assign idx         = match_found ? match_idx : free_idx;

endmodule

// ===== design/node_table_upsert.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    packet fields (source id .. air index)
// out      output     out_valid/out_ready  slot, outcome, reading_stored, node_packets
// cfg      input      cfg_wr_en            cfg_wr_data (expected payload length)
//
// Each item passes ST_IDLE, where id match and record read happen on the accept edge,
// then ST_UPDATE, where write-back and result load use the registered read of the record RAM.
// The result sits in an output register; the next item is taken while it waits.
// If the output register is still full and out_ready is low, the write-back cycle holds.
// Reset (rst_n low, synchronous) clears active flags and control state at once.
`include "node_table_upsert_defines.svh"

module node_table_upsert #(
  parameter int TABLE_ENTRIES = ntu_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ntu_pkg::LEN_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ntu_pkg::ID_W-1:0]      in_src_id,
  input  logic                          in_is_data,
  input  logic [ntu_pkg::LEN_W-1:0]     in_pkt_len,
  input  logic signed [7:0]             in_rssi,
  input  logic [7:0]                    in_hops,
  input  logic [31:0]                   in_now_ms,
  input  logic signed [15:0]            in_temperature_centi,
  input  logic [15:0]                   in_humidity_centi,
  input  logic [15:0]                   in_co2_level,
  input  logic [15:0]                   in_voc_level,
  input  logic [15:0]                   in_pm25_level,
  input  logic [7:0]                    in_air_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ntu_pkg::SLOT_W-1:0]    out_slot,
  output logic [1:0]                    out_outcome,
  output logic                          out_reading_stored,
  output logic [31:0]                   out_node_packets
);
  import ntu_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]                   cfg_len_r;
  logic [TABLE_ENTRIES-1:0]           entry_active_r;
  logic [TABLE_ENTRIES-1:0][ID_W-1:0] entry_id_r;

  stat_t    stat_mem [TABLE_ENTRIES];
  reading_t read_mem [TABLE_ENTRIES];
  stat_t    rd_stat_r;

  lookup_t          lk_flags;
  logic [IDX_W-1:0] lk_idx;
  logic [IDX_W-1:0] rd_addr;

  logic [IDX_W-1:0]  hit_r;
  outcome_t          outcome_r;
  logic [ID_W-1:0]   id_r;
  logic              store_r;
  stat_t             new_stat_r;
  reading_t          reading_r;

  logic        out_valid_r;
  logic [SLOT_W-1:0] out_slot_r;
  outcome_t    out_outcome_r;
  logic        out_stored_r;
  logic [31:0] out_packets_r;

  logic        accept;
  logic        finish;
  logic [31:0] count_new;
  stat_t       wr_stat;
  reading_t    wr_reading;

  ntu_lookup #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_lookup (
    .active(entry_active_r),
    .ids   (entry_id_r),
    .key   (in_src_id),
    .flags (lk_flags),
    .idx   (lk_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    accept    = 1'b0;
    finish    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (in_valid) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        finish = !out_valid_r || out_ready;
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= CFG_LEN_RESET;
    end else if (cfg_wr_en) begin
      cfg_len_r <= cfg_wr_data;
    end
  end

  // Record RAM read; address holds during the update state.
  assign rd_addr = (state_r == ST_IDLE) ? lk_idx : hit_r;

  always_ff @(posedge clk) begin
    rd_stat_r <= stat_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r   <= lk_idx;
      id_r    <= in_src_id;
      store_r <= in_is_data && (in_pkt_len == cfg_len_r);
      if (lk_flags.match) begin
        outcome_r <= OUT_UPDATED;
      end else if (lk_flags.free) begin
        outcome_r <= OUT_NEW;
      end else begin
        outcome_r <= OUT_FULL;
      end
      new_stat_r.count     <= '0;
      new_stat_r.last_seen <= in_now_ms;
      new_stat_r.hops      <= in_hops;
      new_stat_r.rssi      <= in_rssi;
      reading_r.env        <= {in_voc_level, in_co2_level, in_humidity_centi,
                               in_temperature_centi};
      reading_r.particle   <= {in_air_index, in_pm25_level};
    end
  end

  assign count_new = (outcome_r == OUT_NEW) ? 32'd1 : rd_stat_r.count + 32'd1;

  always_comb begin
    wr_stat       = new_stat_r;
    wr_stat.count = count_new;
    wr_reading    = store_r ? reading_r : '0;
  end

  always_ff @(posedge clk) begin
    if (finish && (outcome_r != OUT_FULL)) begin
      stat_mem[hit_r] <= wr_stat;
    end
    if (finish && (store_r || (outcome_r == OUT_NEW)) && (outcome_r != OUT_FULL)) begin
      read_mem[hit_r] <= wr_reading;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_active_r <= '0;
    end else if (finish && (outcome_r == OUT_NEW)) begin
      entry_active_r[hit_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && (outcome_r == OUT_NEW)) begin
      entry_id_r[hit_r] <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_outcome_r <= outcome_r;
      if (outcome_r == OUT_FULL) begin
        out_slot_r    <= '0;
        out_stored_r  <= 1'b0;
        out_packets_r <= '0;
      end else begin
        out_slot_r    <= SLOT_W'(hit_r);
        out_stored_r  <= store_r;
        out_packets_r <= count_new;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_slot           = out_slot_r;
  assign out_outcome        = out_outcome_r;
  assign out_reading_stored = out_stored_r;
  assign out_node_packets   = out_packets_r;

  `NTU_ASSERT_NOW(a_full_zero, out_valid_r && (out_outcome_r == OUT_FULL), (out_slot_r == '0) && !out_stored_r && (out_packets_r == '0), "full result fields not zero")
  `NTU_ASSERT_NOW(a_new_count, out_valid_r && (out_outcome_r == OUT_NEW), out_packets_r == 32'd1, "new entry count not one")
  `NTU_ASSERT_NEXT(a_claim_active, finish && (outcome_r == OUT_NEW), entry_active_r[$past(hit_r)], "claimed slot not active")
  `NTU_ASSERT_NEXT(a_active_grow, 1'b1, $countones(entry_active_r) >= $countones($past(entry_active_r)), "active entry lost")

endmodule

// ===== test/node_table_upsert_tb.sv =====
`timescale 1ns / 1ps

module node_table_upsert_tb;
  import ntu_pkg::*;

  localparam int SLOTS       = DEF_TABLE_ENTRIES;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 100;
  localparam int DRAIN       = 20;

  typedef struct {
    logic [ID_W-1:0]   src_id;
    logic              is_data;
    logic [LEN_W-1:0]  pkt_len;
    logic signed [7:0] rssi;
    logic [7:0]        hops;
    logic [31:0]       now_ms;
    logic signed [15:0] temperature_centi;
    logic [15:0]       humidity_centi;
    logic [15:0]       co2_level;
    logic [15:0]       voc_level;
    logic [15:0]       pm25_level;
    logic [7:0]        air_index;
  } packet_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    outcome_t          outcome;
    logic              reading_stored;
    logic [31:0]       node_packets;
  } upsert_res_t;

  typedef struct {
    packet_t     pkt;
    bit          typed;
    upsert_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ID_W-1:0] in_src_id = '0;
  logic in_is_data = 1'b0;
  logic [LEN_W-1:0] in_pkt_len = '0;
  logic signed [7:0] in_rssi = '0;
  logic [7:0] in_hops = '0;
  logic [31:0] in_now_ms = '0;
  logic signed [15:0] in_temperature_centi = '0;
  logic [15:0] in_humidity_centi = '0;
  logic [15:0] in_co2_level = '0;
  logic [15:0] in_voc_level = '0;
  logic [15:0] in_pm25_level = '0;
  logic [7:0] in_air_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SLOT_W-1:0] out_slot;
  logic [1:0] out_outcome;
  logic out_reading_stored;
  logic [31:0] out_node_packets;

  // node table as the testbench sees it
  logic        node_active [SLOTS];
  logic [7:0]  node_id [SLOTS];
  logic [31:0] node_count [SLOTS];
  logic [7:0]  exp_len;

  upsert_res_t pending_q[$];
  dir_row_t    dir_rows[$];
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  int          errs = 0;
  int          cycles = 0;

  node_table_upsert u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_src_id            (in_src_id),
    .in_is_data           (in_is_data),
    .in_pkt_len           (in_pkt_len),
    .in_rssi              (in_rssi),
    .in_hops              (in_hops),
    .in_now_ms            (in_now_ms),
    .in_temperature_centi (in_temperature_centi),
    .in_humidity_centi    (in_humidity_centi),
    .in_co2_level         (in_co2_level),
    .in_voc_level         (in_voc_level),
    .in_pm25_level        (in_pm25_level),
    .in_air_index         (in_air_index),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_slot             (out_slot),
    .out_outcome          (out_outcome),
    .out_reading_stored   (out_reading_stored),
    .out_node_packets     (out_node_packets)
  );

  always #5 clk = ~clk;

  function automatic upsert_res_t upsert_predict(packet_t p);
    upsert_res_t r;
    int hit;
    hit = -1;
    for (int k = 0; k < SLOTS; k++)
      if (hit < 0 && node_active[k] && node_id[k] == p.src_id) hit = k;
    r.outcome = OUT_UPDATED;
    if (hit < 0) begin
      for (int k = 0; k < SLOTS; k++)
        if (hit < 0 && !node_active[k]) hit = k;
      if (hit < 0) begin
        r.slot = '0;
        r.outcome = OUT_FULL;
        r.reading_stored = 1'b0;
        r.node_packets = '0;
        return r;
      end
      node_active[hit] = 1'b1;
      node_id[hit] = p.src_id;
      node_count[hit] = '0;
      r.outcome = OUT_NEW;
    end
    node_count[hit] = node_count[hit] + 32'd1;
    r.slot = hit[SLOT_W-1:0];
    r.reading_stored = p.is_data && (p.pkt_len == exp_len);
    r.node_packets = node_count[hit];
    return r;
  endfunction

  function automatic packet_t mk_pkt(logic [7:0] id, logic d, logic [7:0] len,
                                     logic signed [7:0] rssi, logic [7:0] hops,
                                     logic [31:0] now, logic signed [15:0] temp,
                                     logic [15:0] hum, logic [15:0] co2, logic [15:0] voc,
                                     logic [15:0] pm, logic [7:0] air);
    packet_t p;
    p.src_id = id;
    p.is_data = d;
    p.pkt_len = len;
    p.rssi = rssi;
    p.hops = hops;
    p.now_ms = now;
    p.temperature_centi = temp;
    p.humidity_centi = hum;
    p.co2_level = co2;
    p.voc_level = voc;
    p.pm25_level = pm;
    p.air_index = air;
    return p;
  endfunction

  // mostly ids already in the table, the rest arbitrary (table full once all slots are taken)
  function automatic packet_t rand_pkt();
    packet_t p;
    int pick;
    p = mk_pkt(8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               $urandom, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 8'($urandom));
    if ($urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, SLOTS - 1);
      if (node_active[pick]) p.src_id = node_id[pick];
    end
    if ($urandom_range(0, 1) == 1) p.pkt_len = exp_len;
    return p;
  endfunction

  function automatic packet_t with_key(logic [7:0] id, logic d, logic [7:0] len);
    packet_t p;
    p = rand_pkt();
    p.src_id = id;
    p.is_data = d;
    p.pkt_len = len;
    return p;
  endfunction

  task automatic add_row(packet_t p, bit typed, logic [SLOT_W-1:0] s, outcome_t o,
                         logic st, logic [31:0] n);
    dir_row_t row;
    row.pkt = p;
    row.typed = typed;
    row.res.slot = s;
    row.res.outcome = o;
    row.res.reading_stored = st;
    row.res.node_packets = n;
    dir_rows.push_back(row);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_packet(packet_t p, bit typed, upsert_res_t want);
    upsert_res_t r;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_src_id <= p.src_id;
    in_is_data <= p.is_data;
    in_pkt_len <= p.pkt_len;
    in_rssi <= p.rssi;
    in_hops <= p.hops;
    in_now_ms <= p.now_ms;
    in_temperature_centi <= p.temperature_centi;
    in_humidity_centi <= p.humidity_centi;
    in_co2_level <= p.co2_level;
    in_voc_level <= p.voc_level;
    in_pm25_level <= p.pm25_level;
    in_air_index <= p.air_index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = upsert_predict(p);
    if (typed) pending_q.push_back(want);
    else pending_q.push_back(r);
    @(negedge clk);
  endtask

  task automatic write_len(logic [7:0] v);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    exp_len = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);

  always @(posedge clk) begin
    upsert_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected item: slot %0d outcome %0d", out_slot, out_outcome);
        errs++;
      end else begin
        e = pending_q.pop_front();
        check_field("slot", 32'(e.slot), 32'(out_slot));
        check_field("outcome", 32'(e.outcome), 32'(out_outcome));
        check_field("reading_stored", 32'(e.reading_stored), 32'(out_reading_stored));
        check_field("node_packets", e.node_packets, out_node_packets);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[node_table_upsert] ERROR");
      $finish;
    end
  end

  initial begin
    upsert_res_t none;
    logic [7:0] len_plan [4];
    none.slot = '0;
    none.outcome = OUT_UPDATED;
    none.reading_stored = 1'b0;
    none.node_packets = '0;
    exp_len = CFG_LEN_RESET;
    for (int k = 0; k < SLOTS; k++) begin
      node_active[k] = 1'b0;
      node_id[k] = '0;
      node_count[k] = '0;
    end

    add_row(mk_pkt(8'h00, 1'b1, 8'd11, -8'sd128, 8'h00, 32'h0, -16'sd32768,
                   16'h0, 16'h0, 16'h0, 16'h0, 8'h00), 1, 0, OUT_NEW, 1, 1);
    add_row(mk_pkt(8'hFF, 1'b1, 8'd11, 8'sd127, 8'hFF, 32'hFFFF_FFFF, 16'sd32767,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1, 1, OUT_NEW, 1, 1);
    add_row(with_key(8'h00, 1'b1, 8'd10), 1, 0, OUT_UPDATED, 0, 2);
    add_row(with_key(8'hFF, 1'b0, 8'd11), 1, 1, OUT_UPDATED, 0, 2);
    add_row(with_key(8'h00, 1'b1, 8'd255), 1, 0, OUT_UPDATED, 0, 3);
    add_row(with_key(8'h00, 1'b1, 8'd0), 0, 0, OUT_UPDATED, 0, 0);
    add_row(with_key(8'h55, 1'b1, 8'd11), 0, 0, OUT_UPDATED, 0, 0);
    add_row(with_key(8'hAA, 1'b0, 8'd0), 0, 0, OUT_UPDATED, 0, 0);
    for (int i = 1; i <= 12; i++)
      add_row(with_key(8'(i), 1'b1, 8'd11), 0, 0, OUT_UPDATED, 0, 0);
    // all 16 slots taken now
    add_row(with_key(8'h80, 1'b1, 8'd11), 1, 0, OUT_FULL, 0, 0);
    add_row(mk_pkt(8'h7F, 1'b1, 8'd11, 8'sd127, 8'hFF, 32'hFFFF_FFFF, 16'sd32767,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1, 0, OUT_FULL, 0, 0);
    add_row(with_key(8'h0C, 1'b1, 8'd11), 0, 0, OUT_UPDATED, 0, 0);

    len_plan[0] = 8'd0;
    len_plan[1] = 8'd255;
    len_plan[2] = 8'($urandom_range(1, 254));
    len_plan[3] = CFG_LEN_RESET;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_packet(dir_rows[i].pkt, dir_rows[i].typed, dir_rows[i].res);
    in_valid <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 0;
        end
        1: begin
          snd_idle_pct = 75;
          rcv_stall_pct = 0;
        end
        2: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 75;
        end
        default: begin
          snd_idle_pct = 32;
          rcv_stall_pct = 32;
        end
      endcase
      write_len(len_plan[ph]);
      repeat (PHASE_ITEMS) send_packet(rand_pkt(), 0, none);
      in_valid <= 1'b0;
    end

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errs == 0) begin
      $display("[node_table_upsert] OK");
    end else begin
      $display("[node_table_upsert] ERROR");
    end
    $finish;
  end

endmodule

// ===== node_table_upsert.f =====
+incdir+design
design/ntu_pkg.sv
design/ntu_lookup.sv
design/node_table_upsert.sv
test/node_table_upsert_tb.sv
